### sv/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define NPT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define NPT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### sv/nptri_pkg.sv
// Types, widths and constants shared by the nearest-point-on-triangle block.
package nptri_pkg;

   localparam int CW  = 32;            // coordinate width
   localparam int DFW = CW + 1;        // coordinate difference
   localparam int PW  = 2 * DFW;       // product of two differences
   localparam int XW  = PW + 1;        // cross product component
   localparam int P2W = 2 * XW;        // product of two cross components
   localparam int NNW = P2W + 2;       // sum of three such products
   localparam int ANW = NNW + 2;       // first barycentric numerator
   localparam int EDW = PW + 2;        // edge dot products
   localparam int FPW = DFW + NNW;     // face interpolation product
   localparam int FTW = FPW + 1;       // face interpolation sum
   localparam int EPW = DFW + EDW;     // edge interpolation product
   localparam int DVT = FTW + 2;       // divider numerator
   localparam int DVD = NNW;           // divider denominator
   localparam int QB  = CW + 4;        // quotient bits
   localparam int QW  = QB + 1;        // signed quotient
   localparam int RW  = QW + 1;        // result before saturation
   localparam int DSW = PW + 2;        // squared distance
   localparam int NDIV = 12;           // a face quotient and an edge quotient per edge for each axis

   localparam int HW  = 34;            // limb width of a split multiplication
   localparam int LB  = XW - HW;       // low limb bits of a cross component
   localparam int LPW = 2 * HW;        // partial product
   localparam int NFL = NNW / HW;      // limbs of a barycentric numerator
   localparam int NEL = EDW / HW;      // limbs of an edge numerator

   localparam int NXT [3] = '{1, 2, 0};
   localparam int NX2 [3] = '{2, 0, 1};

   typedef enum logic [1:0] {
      ESEL_START = 2'd0,
      ESEL_END   = 2'd1,
      ESEL_DIV   = 2'd2
   } esel_type;

   typedef struct packed {
      logic signed [CW-1:0] query_x;
      logic signed [CW-1:0] query_y;
      logic signed [CW-1:0] query_z;
      logic signed [CW-1:0] vertex_a_x;
      logic signed [CW-1:0] vertex_a_y;
      logic signed [CW-1:0] vertex_a_z;
      logic signed [CW-1:0] vertex_b_x;
      logic signed [CW-1:0] vertex_b_y;
      logic signed [CW-1:0] vertex_b_z;
      logic signed [CW-1:0] vertex_c_x;
      logic signed [CW-1:0] vertex_c_y;
      logic signed [CW-1:0] vertex_c_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] near_x;
      logic signed [CW-1:0] near_y;
      logic signed [CW-1:0] near_z;
      logic                 on_face;
      logic                 degenerate;
   } rsp_type;

   // Points are indexed query, A, B, C; edge selects are AB, BC, CA.
   typedef struct packed {
      logic [3:0][2:0][CW-1:0] pt;
      logic                    on_face;
      logic                    degen;
      esel_type [2:0]          esel;
   } side_type;

endpackage

### sv/nptri_ifs.sv
// Valid/ready channel interfaces for query and result beats.
interface nptri_req_if;
   logic               valid;
   logic               ready;
   nptri_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface nptri_rsp_if;
   logic               valid;
   logic               ready;
   nptri_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/nptri_div.sv
// Pipelined restoring divider giving floor(num / den) for a positive denominator.
module nptri_div (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [nptri_pkg::DVT-1:0] in_num,
   input  logic        [nptri_pkg::DVD-1:0] in_den,
   output logic signed [nptri_pkg::QW-1:0]  out_quo
);
   import nptri_pkg::*;

   logic [DVT-1:0] rem_ff [QB+1];
   logic [QB-1:0]  quo_ff [QB+1];
   logic [DVD-1:0] den_ff [QB+1];
   logic           neg_ff [QB+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= in_num[DVT-1] ? DVT'(-in_num) : DVT'(in_num);
         quo_ff[0] <= '0;
         den_ff[0] <= in_den;
         neg_ff[0] <= in_num[DVT-1];
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_stage
      logic [DVT-1:0] shd_w;
      logic           fit_w;
      assign shd_w = DVT'(den_ff[j-1]) << (QB - j);
      assign fit_w = rem_ff[j-1] >= shd_w;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= fit_w ? rem_ff[j-1] - shd_w : rem_ff[j-1];
            quo_ff[j] <= quo_ff[j-1] | (fit_w ? (QB'(1) << (QB - j)) : '0);
            den_ff[j] <= den_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   // A negative numerator with a remainder rounds one further down.
   assign out_quo = neg_ff[QB]
      ? -(QW'(quo_ff[QB]) + QW'(rem_ff[QB] != '0))
      : QW'(quo_ff[QB]);

endmodule

### sv/nptri_geom.sv
// Front pipeline: differences, normal, barycentric numerators and divider operands.
module nptri_geom (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  nptri_pkg::req_type               in_data,
   output logic                             out_valid,
   output nptri_pkg::side_type              out_side,
   output logic signed [nptri_pkg::DVT-1:0] out_num [nptri_pkg::NDIV],
   output logic        [nptri_pkg::DVD-1:0] out_den [nptri_pkg::NDIV]
);
   import nptri_pkg::*;

   logic signed [CW-1:0] vt_w [4][3];
   logic [3:0][2:0][CW-1:0] pt_w;

   logic [8:0] vld_ff;
   logic [3:0][2:0][CW-1:0] pt_ff [8];

   logic signed [DFW-1:0] u1_ff [3], v1_ff [3], w1_ff [3];
   logic signed [DFW-1:0] d1_ff [3][3], ps1_ff [3][3];

   logic signed [PW-1:0]  pna2_ff [3], pnb2_ff [3], pga2_ff [3], pgb2_ff [3];
   logic signed [PW-1:0]  pba2_ff [3], pbb2_ff [3];
   logic signed [PW-1:0]  dd2_ff [3][3], pd2_ff [3][3];
   logic signed [DFW-1:0] u2_ff [3], v2_ff [3], d2_ff [3][3];

   logic signed [XW-1:0]  n3_ff [3], g3_ff [3], b3_ff [3];
   logic signed [EDW-1:0] den3_ff [3], num3_ff [3];
   logic signed [DFW-1:0] u3_ff [3], v3_ff [3], d3_ff [3][3];

   logic signed [HW-1:0]  nh_w [3], nl_w [3], gh_w [3], gl_w [3], bh_w [3], bl_w [3];
   logic signed [LPW-1:0] nhh4_ff [3], nhl4_ff [3], nll4_ff [3];
   logic signed [LPW-1:0] ghh4_ff [3], ghl4_ff [3], glh4_ff [3], gll4_ff [3];
   logic signed [LPW-1:0] bhh4_ff [3], bhl4_ff [3], blh4_ff [3], bll4_ff [3];
   logic signed [EDW-1:0] den4_ff [3], num4_ff [3];
   logic signed [DFW-1:0] u4_ff [3], v4_ff [3], d4_ff [3][3];

   logic signed [P2W-1:0] sq5_ff [3], gp5_ff [3], bp5_ff [3];
   logic signed [EDW-1:0] den5_ff [3], num5_ff [3];
   logic signed [DFW-1:0] u5_ff [3], v5_ff [3], d5_ff [3][3];

   logic signed [NNW-1:0] nn6_ff, gn6_ff, bn6_ff;
   esel_type              esel6_ff [3];
   logic signed [EDW-1:0] den6_ff [3], num6_ff [3];
   logic signed [DFW-1:0] u6_ff [3], v6_ff [3], d6_ff [3][3];

   logic signed [ANW-1:0] an_w;
   logic signed [HW:0]    bnl_w [NFL], gnl_w [NFL], nml_w [3][NEL];
   logic signed [LPW-1:0] fu7_ff [3][NFL], fv7_ff [3][NFL];
   logic signed [LPW-1:0] ep7_ff [3][3][NEL];
   logic signed [NNW-1:0] nn7_ff;
   logic signed [EDW-1:0] den7_ff [3];
   esel_type              esel7_ff [3];
   logic                  face7_ff, degen7_ff;

   logic signed [FPW-1:0] fu_w [3], fv_w [3];
   logic signed [EPW-1:0] ep_w [3][3];
   logic signed [FPW-1:0] fu8_ff [3], fv8_ff [3];
   logic signed [EPW-1:0] ep8_ff [3][3];
   logic signed [NNW-1:0] nn8_ff;
   logic signed [EDW-1:0] den8_ff [3];
   esel_type              esel8_ff [3];
   logic                  face8_ff, degen8_ff;

   logic signed [DVT-1:0] num9_ff [NDIV];
   logic        [DVD-1:0] den9_ff [NDIV];
   side_type              side9_ff;

   always_comb begin
      vt_w[0][0] = in_data.query_x;
      vt_w[0][1] = in_data.query_y;
      vt_w[0][2] = in_data.query_z;
      vt_w[1][0] = in_data.vertex_a_x;
      vt_w[1][1] = in_data.vertex_a_y;
      vt_w[1][2] = in_data.vertex_a_z;
      vt_w[2][0] = in_data.vertex_b_x;
      vt_w[2][1] = in_data.vertex_b_y;
      vt_w[2][2] = in_data.vertex_b_z;
      vt_w[3][0] = in_data.vertex_c_x;
      vt_w[3][1] = in_data.vertex_c_y;
      vt_w[3][2] = in_data.vertex_c_z;
      for (int q = 0; q < 4; q++) begin
         for (int i = 0; i < 3; i++) begin
            pt_w[q][i] = vt_w[q][i];
         end
      end
   end

   // Cross components split into a signed high limb and an unsigned low limb.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nh_w[i] = n3_ff[i][XW-1:LB];
         nl_w[i] = {1'b0, n3_ff[i][LB-1:0]};
         gh_w[i] = g3_ff[i][XW-1:LB];
         gl_w[i] = {1'b0, g3_ff[i][LB-1:0]};
         bh_w[i] = b3_ff[i][XW-1:LB];
         bl_w[i] = {1'b0, b3_ff[i][LB-1:0]};
      end
   end

   // Numerators split into unsigned low limbs and a signed top limb.
   always_comb begin
      for (int k = 0; k < NFL; k++) begin
         if (k == NFL - 1) begin
            bnl_w[k] = {bn6_ff[NNW-1], bn6_ff[HW*k +: HW]};
            gnl_w[k] = {gn6_ff[NNW-1], gn6_ff[HW*k +: HW]};
         end else begin
            bnl_w[k] = {1'b0, bn6_ff[HW*k +: HW]};
            gnl_w[k] = {1'b0, gn6_ff[HW*k +: HW]};
         end
      end
      for (int e = 0; e < 3; e++) begin
         for (int k = 0; k < NEL; k++) begin
            if (k == NEL - 1) begin
               nml_w[e][k] = {num6_ff[e][EDW-1], num6_ff[e][HW*k +: HW]};
            end else begin
               nml_w[e][k] = {1'b0, num6_ff[e][HW*k +: HW]};
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fu_w[i] = '0;
         fv_w[i] = '0;
         for (int k = 0; k < NFL; k++) begin
            fu_w[i] = fu_w[i] + (FPW'(fu7_ff[i][k]) <<< (HW * k));
            fv_w[i] = fv_w[i] + (FPW'(fv7_ff[i][k]) <<< (HW * k));
         end
         for (int e = 0; e < 3; e++) begin
            ep_w[e][i] = '0;
            for (int k = 0; k < NEL; k++) begin
               ep_w[e][i] = ep_w[e][i] + (EPW'(ep7_ff[e][i][k]) <<< (HW * k));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[7:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff[0] <= pt_w;
         for (int s = 1; s < 8; s++) begin
            pt_ff[s] <= pt_ff[s-1];
         end

         for (int i = 0; i < 3; i++) begin
            u1_ff[i] <= DFW'(vt_w[2][i]) - DFW'(vt_w[1][i]);
            v1_ff[i] <= DFW'(vt_w[3][i]) - DFW'(vt_w[1][i]);
            w1_ff[i] <= DFW'(vt_w[0][i]) - DFW'(vt_w[1][i]);
            for (int e = 0; e < 3; e++) begin
               d1_ff[e][i]  <= DFW'(vt_w[NXT[e]+1][i]) - DFW'(vt_w[e+1][i]);
               ps1_ff[e][i] <= DFW'(vt_w[0][i]) - DFW'(vt_w[e+1][i]);
            end
         end

         for (int i = 0; i < 3; i++) begin
            pna2_ff[i] <= PW'(u1_ff[NXT[i]]) * PW'(v1_ff[NX2[i]]);
            pnb2_ff[i] <= PW'(u1_ff[NX2[i]]) * PW'(v1_ff[NXT[i]]);
            pga2_ff[i] <= PW'(u1_ff[NXT[i]]) * PW'(w1_ff[NX2[i]]);
            pgb2_ff[i] <= PW'(u1_ff[NX2[i]]) * PW'(w1_ff[NXT[i]]);
            pba2_ff[i] <= PW'(w1_ff[NXT[i]]) * PW'(v1_ff[NX2[i]]);
            pbb2_ff[i] <= PW'(w1_ff[NX2[i]]) * PW'(v1_ff[NXT[i]]);
            u2_ff[i] <= u1_ff[i];
            v2_ff[i] <= v1_ff[i];
            for (int e = 0; e < 3; e++) begin
               dd2_ff[e][i] <= PW'(d1_ff[e][i]) * PW'(d1_ff[e][i]);
               pd2_ff[e][i] <= PW'(ps1_ff[e][i]) * PW'(d1_ff[e][i]);
               d2_ff[e][i]  <= d1_ff[e][i];
            end
         end

         for (int i = 0; i < 3; i++) begin
            n3_ff[i] <= XW'(pna2_ff[i]) - XW'(pnb2_ff[i]);
            g3_ff[i] <= XW'(pga2_ff[i]) - XW'(pgb2_ff[i]);
            b3_ff[i] <= XW'(pba2_ff[i]) - XW'(pbb2_ff[i]);
            u3_ff[i] <= u2_ff[i];
            v3_ff[i] <= v2_ff[i];
            den3_ff[i] <= EDW'(dd2_ff[i][0]) + EDW'(dd2_ff[i][1]) + EDW'(dd2_ff[i][2]);
            num3_ff[i] <= EDW'(pd2_ff[i][0]) + EDW'(pd2_ff[i][1]) + EDW'(pd2_ff[i][2]);
            for (int e = 0; e < 3; e++) begin
               d3_ff[e][i] <= d2_ff[e][i];
            end
         end

         for (int i = 0; i < 3; i++) begin
            nhh4_ff[i] <= LPW'(nh_w[i]) * LPW'(nh_w[i]);
            nhl4_ff[i] <= LPW'(nh_w[i]) * LPW'(nl_w[i]);
            nll4_ff[i] <= LPW'(nl_w[i]) * LPW'(nl_w[i]);
            ghh4_ff[i] <= LPW'(gh_w[i]) * LPW'(nh_w[i]);
            ghl4_ff[i] <= LPW'(gh_w[i]) * LPW'(nl_w[i]);
            glh4_ff[i] <= LPW'(gl_w[i]) * LPW'(nh_w[i]);
            gll4_ff[i] <= LPW'(gl_w[i]) * LPW'(nl_w[i]);
            bhh4_ff[i] <= LPW'(bh_w[i]) * LPW'(nh_w[i]);
            bhl4_ff[i] <= LPW'(bh_w[i]) * LPW'(nl_w[i]);
            blh4_ff[i] <= LPW'(bl_w[i]) * LPW'(nh_w[i]);
            bll4_ff[i] <= LPW'(bl_w[i]) * LPW'(nl_w[i]);
            u4_ff[i] <= u3_ff[i];
            v4_ff[i] <= v3_ff[i];
            den4_ff[i] <= den3_ff[i];
            num4_ff[i] <= num3_ff[i];
            for (int e = 0; e < 3; e++) begin
               d4_ff[e][i] <= d3_ff[e][i];
            end
         end

         for (int i = 0; i < 3; i++) begin
            sq5_ff[i] <= (P2W'(nhh4_ff[i]) <<< (2 * LB)) + (P2W'(nhl4_ff[i]) <<< (LB + 1))
                         + P2W'(nll4_ff[i]);
            gp5_ff[i] <= (P2W'(ghh4_ff[i]) <<< (2 * LB))
                         + ((P2W'(ghl4_ff[i]) + P2W'(glh4_ff[i])) <<< LB) + P2W'(gll4_ff[i]);
            bp5_ff[i] <= (P2W'(bhh4_ff[i]) <<< (2 * LB))
                         + ((P2W'(bhl4_ff[i]) + P2W'(blh4_ff[i])) <<< LB) + P2W'(bll4_ff[i]);
            u5_ff[i] <= u4_ff[i];
            v5_ff[i] <= v4_ff[i];
            den5_ff[i] <= den4_ff[i];
            num5_ff[i] <= num4_ff[i];
            for (int e = 0; e < 3; e++) begin
               d5_ff[e][i] <= d4_ff[e][i];
            end
         end

         nn6_ff <= NNW'(sq5_ff[0]) + NNW'(sq5_ff[1]) + NNW'(sq5_ff[2]);
         gn6_ff <= NNW'(gp5_ff[0]) + NNW'(gp5_ff[1]) + NNW'(gp5_ff[2]);
         bn6_ff <= NNW'(bp5_ff[0]) + NNW'(bp5_ff[1]) + NNW'(bp5_ff[2]);
         for (int i = 0; i < 3; i++) begin
            if (den5_ff[i] == 0 || num5_ff[i] <= 0) begin
               esel6_ff[i] <= ESEL_START;
            end else if (num5_ff[i] >= den5_ff[i]) begin
               esel6_ff[i] <= ESEL_END;
            end else begin
               esel6_ff[i] <= ESEL_DIV;
            end
            u6_ff[i] <= u5_ff[i];
            v6_ff[i] <= v5_ff[i];
            den6_ff[i] <= den5_ff[i];
            num6_ff[i] <= num5_ff[i];
            for (int e = 0; e < 3; e++) begin
               d6_ff[e][i] <= d5_ff[e][i];
            end
         end

         face7_ff  <= nn6_ff != 0 && an_w >= 0 && an_w <= ANW'(nn6_ff)
                      && gn6_ff >= 0 && gn6_ff <= nn6_ff
                      && bn6_ff >= 0 && bn6_ff <= nn6_ff;
         degen7_ff <= nn6_ff == 0;
         nn7_ff    <= nn6_ff;
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < NFL; k++) begin
               fu7_ff[i][k] <= LPW'(u6_ff[i]) * LPW'(bnl_w[k]);
               fv7_ff[i][k] <= LPW'(v6_ff[i]) * LPW'(gnl_w[k]);
            end
            den7_ff[i]  <= den6_ff[i];
            esel7_ff[i] <= esel6_ff[i];
            for (int e = 0; e < 3; e++) begin
               for (int k = 0; k < NEL; k++) begin
                  ep7_ff[e][i][k] <= LPW'(d6_ff[e][i]) * LPW'(nml_w[e][k]);
               end
            end
         end

         face8_ff  <= face7_ff;
         degen8_ff <= degen7_ff;
         nn8_ff    <= nn7_ff;
         for (int i = 0; i < 3; i++) begin
            fu8_ff[i]   <= fu_w[i];
            fv8_ff[i]   <= fv_w[i];
            den8_ff[i]  <= den7_ff[i];
            esel8_ff[i] <= esel7_ff[i];
            for (int e = 0; e < 3; e++) begin
               ep8_ff[e][i] <= ep_w[e][i];
            end
         end

         for (int i = 0; i < 3; i++) begin
            num9_ff[i] <= ((DVT'(fu8_ff[i]) + DVT'(fv8_ff[i])) <<< 1) + DVT'(nn8_ff);
            den9_ff[i] <= DVD'(nn8_ff) << 1;
            for (int e = 0; e < 3; e++) begin
               num9_ff[3+3*e+i] <= (DVT'(ep8_ff[e][i]) <<< 1) + DVT'(den8_ff[e]);
               den9_ff[3+3*e+i] <= DVD'(den8_ff[e]) << 1;
            end
         end
         side9_ff.pt      <= pt_ff[7];
         side9_ff.on_face <= face8_ff;
         side9_ff.degen   <= degen8_ff;
         for (int e = 0; e < 3; e++) begin
            side9_ff.esel[e] <= esel8_ff[e];
         end
      end
   end

   assign an_w = ANW'(nn6_ff) - ANW'(gn6_ff) - ANW'(bn6_ff);

   assign out_valid = vld_ff[8];
   assign out_side  = side9_ff;
   assign out_num   = num9_ff;
   assign out_den   = den9_ff;

endmodule

### sv/nptri_pick.sv
// Back pipeline: candidate points, squared distances, selection and saturation.
module nptri_pick (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  nptri_pkg::side_type             in_side,
   input  logic signed [nptri_pkg::QW-1:0] in_quo [nptri_pkg::NDIV],
   output logic                            out_valid,
   output nptri_pkg::rsp_type              out_data
);
   import nptri_pkg::*;

   localparam logic signed [RW-1:0] SMAX = RW'($signed({1'b0, {(CW-1){1'b1}}}));
   localparam logic signed [RW-1:0] SMIN = RW'($signed({1'b1, {(CW-1){1'b0}}}));

   function automatic logic signed [CW-1:0] sat_f(input logic signed [RW-1:0] x);
      logic signed [RW-1:0] y;
      y = x;
      if (x > SMAX) begin
         y = SMAX;
      end else if (x < SMIN) begin
         y = SMIN;
      end
      return y[CW-1:0];
   endfunction

   logic [2:0] vld_ff;

   logic signed [RW-1:0] fc8_ff [3];
   logic signed [CW-1:0] ec8_ff [3][3];
   logic signed [CW-1:0] p8_ff [3];
   logic                 face8_ff, degen8_ff;

   logic signed [DFW-1:0] dq_w [3][3];
   logic        [PW-1:0]  sq9_ff [3][3];
   logic signed [RW-1:0]  fc9_ff [3];
   logic signed [CW-1:0]  ec9_ff [3][3];
   logic                  face9_ff, degen9_ff;

   logic [DSW-1:0] dist_w [3];
   logic [DSW-1:0] best_w;
   logic [1:0]     sel_w;
   rsp_type        out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         face8_ff  <= in_side.on_face;
         degen8_ff <= in_side.degen;
         for (int i = 0; i < 3; i++) begin
            fc8_ff[i] <= RW'($signed(in_side.pt[1][i])) + RW'(in_quo[i]);
            p8_ff[i]  <= $signed(in_side.pt[0][i]);
            for (int e = 0; e < 3; e++) begin
               case (in_side.esel[e])
                  ESEL_START: ec8_ff[e][i] <= $signed(in_side.pt[e+1][i]);
                  ESEL_END:   ec8_ff[e][i] <= $signed(in_side.pt[NXT[e]+1][i]);
                  default:    ec8_ff[e][i] <= CW'(RW'($signed(in_side.pt[e+1][i]))
                                                + RW'(in_quo[3+3*e+i]));
               endcase
            end
         end

         face9_ff  <= face8_ff;
         degen9_ff <= degen8_ff;
         for (int i = 0; i < 3; i++) begin
            fc9_ff[i] <= fc8_ff[i];
            for (int e = 0; e < 3; e++) begin
               sq9_ff[e][i] <= PW'(PW'(dq_w[e][i]) * PW'(dq_w[e][i]));
               ec9_ff[e][i] <= ec8_ff[e][i];
            end
         end

         out_ff.on_face    <= face9_ff;
         out_ff.degenerate <= degen9_ff;
         out_ff.near_x     <= face9_ff ? sat_f(fc9_ff[0]) : ec9_ff[sel_w][0];
         out_ff.near_y     <= face9_ff ? sat_f(fc9_ff[1]) : ec9_ff[sel_w][1];
         out_ff.near_z     <= face9_ff ? sat_f(fc9_ff[2]) : ec9_ff[sel_w][2];
      end
   end

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         for (int i = 0; i < 3; i++) begin
            dq_w[e][i] = DFW'(ec8_ff[e][i]) - DFW'(p8_ff[i]);
         end
         dist_w[e] = DSW'(sq9_ff[e][0]) + DSW'(sq9_ff[e][1]) + DSW'(sq9_ff[e][2]);
      end
      // The earlier edge keeps a tie.
      sel_w  = 2'd0;
      best_w = dist_w[0];
      if (dist_w[1] < best_w) begin
         sel_w  = 2'd1;
         best_w = dist_w[1];
      end
      if (dist_w[2] < best_w) begin
         sel_w = 2'd2;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_data  = out_ff;

endmodule

### sv/nearest_point_on_triangle_top.sv
// Top level of the nearest-point-on-triangle block.
//
// A query beat on req_ch carries a point and three triangle vertices in signed
// Q16.16. For each query one result beat on rsp_ch carries the nearest point of
// the closed triangle, saturated, with on_face and degenerate flags.
// The block takes one query per cycle and keeps that rate indefinitely while the
// receiver takes results. The pipeline has 9 front stages that form the
// normal, the barycentric and edge numerators and the interpolation products from
// narrow partial products, 37 stages of the shared-shape restoring dividers (a load
// stage, then one quotient bit per stage, twelve in parallel), and 3 back stages
// that pick and saturate the result.
// All stages advance together. When a result waits on rsp_ch with ready low, the
// whole pipeline holds and req_ch.ready drops; no beat is lost or repeated.
// Synchronous reset empties the pipeline: rsp_ch.valid is low after reset and
// the next query is accepted in the first cycle after reset falls.
module nearest_point_on_triangle_top (
   input logic         clock,
   input logic         reset,
   nptri_req_if.sink   req_ch,
   nptri_rsp_if.source rsp_ch
);
   import nptri_pkg::*;

   logic                  adv_w;
   logic                  gm_valid_w;
   side_type              gm_side_w;
   logic signed [DVT-1:0] gm_num_w [NDIV];
   logic        [DVD-1:0] gm_den_w [NDIV];
   logic signed [QW-1:0]  quo_w [NDIV];
   logic [QB:0]           vd_ff;
   side_type              side_ff [QB+1];
   logic                  pk_valid_w;
   rsp_type               pk_data_w;

   assign adv_w        = !pk_valid_w || rsp_ch.ready;
   assign req_ch.ready = adv_w;

   nptri_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .en        (adv_w),
      .in_valid  (req_ch.valid),
      .in_data   (req_ch.payload),
      .out_valid (gm_valid_w),
      .out_side  (gm_side_w),
      .out_num   (gm_num_w),
      .out_den   (gm_den_w)
   );

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      nptri_div u_div (
         .clock   (clock),
         .en      (adv_w),
         .in_num  (gm_num_w[k]),
         .in_den  (gm_den_w[k]),
         .out_quo (quo_w[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= '0;
      end else if (adv_w) begin
         vd_ff <= {vd_ff[QB-1:0], gm_valid_w};
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         side_ff[0] <= gm_side_w;
         for (int j = 1; j <= QB; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   nptri_pick u_pick (
      .clock     (clock),
      .reset     (reset),
      .en        (adv_w),
      .in_valid  (vd_ff[QB]),
      .in_side   (side_ff[QB]),
      .in_quo    (quo_w),
      .out_valid (pk_valid_w),
      .out_data  (pk_data_w)
   );

   assign rsp_ch.valid   = pk_valid_w;
   assign rsp_ch.payload = pk_data_w;

endmodule

### sv/nptri_chk.sv
// Port-level checker for the nearest-point-on-triangle block, with its bind.
`include "assert_macros.svh"

module nptri_chk (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input nptri_pkg::rsp_type rsp_payload
);
   import nptri_pkg::*;

   `NPT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result beat dropped")
   `NPT_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_payload), "result changed")
   `NPT_ASSERT(a_req_stall, !req_ready |-> rsp_valid && !rsp_ready, "input stalled without cause")
   `NPT_ASSERT(a_flags, rsp_valid |-> !(rsp_payload.on_face && rsp_payload.degenerate), "flags clash")
   `NPT_ASSERT_RST(a_reset, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind nearest_point_on_triangle_top nptri_chk u_nptri_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
